FILE: rtl/core/prim_mst_adjacency_matrix_macros.svh
// Assertion macros for the Prim tree block
`ifndef PRIM_MST_ADJACENCY_MATRIX_MACROS_SVH
`define PRIM_MST_ADJACENCY_MATRIX_MACROS_SVH

// Assert a property under the usual clock and reset.
`define PMST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property that also holds through reset.
`define PMST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types and constants for the Prim tree block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmst_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_EXTRACT,
    ST_RELAX_RD,
    ST_RELAX,
    ST_EMIT_SCAN,
    ST_EMIT_EDGE,
    ST_EMIT_TOTAL
  } pmst_state_t;

endpackage

FILE: rtl/core/pmst_ram.sv
// ----------------------------------------------------------------------------
// pmst_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/prim_mst_adjacency_matrix.sv
// ----------------------------------------------------------------------------
// prim_mst_adjacency_matrix
// Prim minimum spanning tree over a stored adjacency matrix.
// ----------------------------------------------------------------------------
// Write item: one per cycle while idle.
// Run item: one shared key compare unit walks the pending list and each matrix row
//   in turn.
// Results: in ready returns as the total is loaded.
// Reset: clears all MAX_VERTICES^2 matrix entries in turn; no item accepted then.
`timescale 1ns / 1ps

module prim_mst_adjacency_matrix
  import pmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  from_vertex,
  input  logic [4:0]  to_vertex,
  input  logic        edge_present,
  input  logic [15:0] weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  parent_vertex,
  output logic [4:0]  child_vertex,
  output logic [15:0] edge_weight,
  output logic [20:0] total_distance,
  output logic        is_total,
  output logic        last
);

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int CB = VB + 1;
  localparam int AB = 2 * VB;
  localparam int KB = WEIGHT_BITS + 1;
  localparam int EW = WEIGHT_BITS + 1;
  localparam int TB = KB + CB;
  localparam logic [KB-1:0] KEY_INF = KB'(1) << WEIGHT_BITS;

  pmst_state_t state, state_next;

  logic [5:0]    vertex_count;
  logic [CB-1:0] n_act;
  logic [VB-1:0] vertex_key_idx;
  logic [KB-1:0] vertex_key [MAX_VERTICES];
  logic [VB-1:0] vertex_parent [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] parent_valid;
  logic [MAX_VERTICES-1:0] in_pending;
  logic [VB-1:0] pending_order [MAX_VERTICES];
  logic [CB-1:0] pending_count;
  logic [CB-1:0] idx;
  logic [VB-1:0] best;
  logic [KB-1:0] best_key;
  logic [VB-1:0] cur_u;
  logic [TB-1:0] total;
  logic [AB:0]   clr_cnt;
  logic [5:0]    in_from_w, in_to_w;

  logic          ram_we;
  logic [AB-1:0] ram_wa, ram_ra;
  logic [EW-1:0] ram_wd, ram_rd;

  // shared key compare unit
  logic [KB-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic [VB-1:0] idx_v;
  assign idx_v = idx[VB-1:0];
  assign vertex_key_idx = pending_order[idx_v];

  always_comb begin
    if (vertex_count == 6'd0) begin
      n_act = CB'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_act = CB'(MAX_VERTICES);
    end else begin
      n_act = CB'(vertex_count);
    end
  end

  assign in_from_w = {1'b0, from_vertex};
  assign in_to_w   = {1'b0, to_vertex};

  logic in_write_ok;
  assign in_write_ok = (32'(in_from_w) < MAX_VERTICES) && (32'(in_to_w) < MAX_VERTICES);

  pmst_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_edges (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_wa),
    .wr_data(ram_wd),
    .rd_addr(ram_ra),
    .rd_data(ram_rd)
  );

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = clr_cnt[AB-1:0];
    ram_wd = '0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_fire && action == ACT_WRITE && in_write_ok) begin
      ram_we = 1'b1;
      ram_wa = {from_vertex[VB-1:0], to_vertex[VB-1:0]};
      ram_wd = edge_present ? {1'b1, weight[WEIGHT_BITS-1:0]} : '0;
    end
  end

  assign ram_ra = {cur_u, idx_v};

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic out_load;
  assign out_load = ((state == ST_EMIT_EDGE) || (state == ST_EMIT_TOTAL)) && out_free;

  logic scan_done, relax_done;
  assign scan_done  = (idx == pending_count);
  assign relax_done = (idx == n_act);

  logic [VB-1:0] ext_v;
  assign ext_v = pending_order[best];

  always_comb begin
    cmp_a = vertex_key[vertex_key_idx];
    cmp_b = best_key;
    if (state == ST_RELAX) begin
      cmp_a = KB'(ram_rd[WEIGHT_BITS-1:0]);
      cmp_b = vertex_key[idx_v];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == (AB+1)'(MAX_VERTICES * MAX_VERTICES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && action == ACT_RUN) state_next = ST_INIT;
      end
      ST_INIT:      state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) state_next = ST_EXTRACT;
      end
      ST_EXTRACT:   state_next = ST_RELAX_RD;
      ST_RELAX_RD: begin
        if (relax_done) begin
          state_next = (pending_count == '0) ? ST_EMIT_SCAN : ST_SCAN;
        end else begin
          state_next = ST_RELAX;
        end
      end
      ST_RELAX:     state_next = ST_RELAX_RD;
      ST_EMIT_SCAN: begin
        if (idx == n_act) state_next = ST_EMIT_TOTAL;
        else if (parent_valid[idx_v]) state_next = ST_EMIT_EDGE;
      end
      ST_EMIT_EDGE: begin
        if (out_free) state_next = ST_EMIT_SCAN;
      end
      ST_EMIT_TOTAL: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      vertex_count <= 6'd32;
      out_valid    <= 1'b0;
      parent_valid <= '0;
      in_pending   <= '0;
      pending_count <= '0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (in_fire && action == ACT_RUN) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
              vertex_key[i]    <= (VB'(i) == from_vertex[VB-1:0] &&
                                   CB'(from_vertex) < n_act) ? '0 : KEY_INF;
              vertex_parent[i] <= '0;
              pending_order[i] <= VB'(i);
              in_pending[i]    <= (CB'(i) < n_act);
            end
            parent_valid  <= '0;
            pending_count <= n_act;
          end
        end
        ST_INIT: begin
          idx      <= CB'(1);
          best     <= '0;
          best_key <= vertex_key[pending_order[0]];
        end
        ST_SCAN: begin
          if (!scan_done) begin
            if (cmp_lt) begin
              best     <= idx_v;
              best_key <= cmp_a;
            end
            idx <= idx + 1'b1;
          end
        end
        ST_EXTRACT: begin
          cur_u <= ext_v;
          in_pending[ext_v] <= 1'b0;
          pending_order[best] <= pending_order[VB'(pending_count - 1'b1)];
          pending_count <= pending_count - 1'b1;
          idx <= '0;
        end
        ST_RELAX_RD: begin
          if (relax_done) begin
            if (pending_count == '0) begin
              idx   <= '0;
              total <= '0;
            end else begin
              idx      <= CB'(1);
              best     <= '0;
              best_key <= vertex_key[pending_order[0]];
            end
          end
        end
        ST_RELAX: begin
          if (ram_rd[EW-1] && in_pending[idx_v] && cmp_lt) begin
            vertex_key[idx_v]    <= cmp_a;
            vertex_parent[idx_v] <= cur_u;
            parent_valid[idx_v]  <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        ST_EMIT_SCAN: begin
          if (idx != n_act && !parent_valid[idx_v]) idx <= idx + 1'b1;
        end
        ST_EMIT_EDGE: begin
          if (out_free) begin
            parent_vertex  <= 5'(vertex_parent[idx_v]);
            child_vertex   <= 5'(idx_v);
            edge_weight    <= 16'(vertex_key[idx_v]);
            total_distance <= '0;
            is_total       <= 1'b0;
            last           <= 1'b0;
            total          <= total + TB'(vertex_key[idx_v]);
            idx            <= idx + 1'b1;
          end
        end
        ST_EMIT_TOTAL: begin
          if (out_free) begin
            parent_vertex  <= '0;
            child_vertex   <= '0;
            edge_weight    <= '0;
            total_distance <= 21'(total);
            is_total       <= 1'b1;
            last           <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/pmst_checker.sv
// ----------------------------------------------------------------------------
// pmst_checker
// Port-level checks for the Prim tree block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prim_mst_adjacency_matrix_macros.svh"

module pmst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        action,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_total,
  input logic        last,
  input logic [20:0] total_distance
);

  `PMST_ASSERT(a_last_is_total, out_valid |-> (last == is_total), "last differs from is_total")
  `PMST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(total_distance), "result dropped")
  `PMST_ASSERT(a_busy_after_run, in_valid && in_ready && action |=> !in_ready, "ready during run")
  `PMST_ASSERT(a_edge_no_total, out_valid && !is_total |-> total_distance == 21'd0, "edge carries total")
  `PMST_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result after reset")

endmodule

bind prim_mst_adjacency_matrix pmst_checker u_pmst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_total      (is_total),
  .last          (last),
  .total_distance(total_distance)
);

FILE: verif/pmst_tree_checker.sv
// ----------------------------------------------------------------------------
// pmst_tree_checker
// Watches the config, input and result channels of the Prim tree block. It
// keeps its own copy of the matrix and vertex count, computes the expected
// tree edges and total for every accepted run item, and compares each
// accepted result against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmst_tree_checker
  import pmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [4:0]  from_vertex,
  input  logic [4:0]  to_vertex,
  input  logic        edge_present,
  input  logic [15:0] weight,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  parent_vertex,
  input  logic [4:0]  child_vertex,
  input  logic [15:0] edge_weight,
  input  logic [20:0] total_distance,
  input  logic        is_total,
  input  logic        last,
  output int          errors,
  output int          outstanding,
  output int          runs_seen,
  output int          results_seen
);

  localparam int NV = 32;
  localparam logic [16:0] KEY_INF = 17'h10000;

  typedef struct packed {
    logic [4:0]  parent;
    logic [4:0]  child;
    logic [15:0] wt;
    logic [20:0] total;
    logic        tot;
    logic        lst;
  } tree_result_t;

  logic [5:0]   count_reg;
  logic         edge_ok [NV*NV];
  logic [15:0]  edge_wt [NV*NV];
  tree_result_t tree_q [$];

  function automatic int used_vertices();
    int n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > NV) n = NV;
    return n;
  endfunction

  task automatic build_tree(input logic [4:0] start);
    logic [16:0] key [NV];
    logic [4:0]  par [NV];
    logic        has_par [NV];
    logic        waiting [NV];
    logic [4:0]  order [NV];
    int          n, left, best, u, e;
    logic [20:0] sum;
    tree_result_t r;
    n = used_vertices();
    for (int i = 0; i < NV; i++) begin
      key[i] = KEY_INF;
      par[i] = '0;
      has_par[i] = 1'b0;
      waiting[i] = 1'b0;
      order[i] = '0;
    end
    if (start < n) key[start] = '0;
    for (int i = 0; i < n; i++) begin
      order[i] = i[4:0];
      waiting[i] = 1'b1;
    end
    left = n;
    while (left > 0) begin
      best = 0;
      for (int i = 1; i < left; i++)
        if (key[order[i]] < key[order[best]]) best = i;
      u = order[best];
      order[best] = order[left-1];
      left--;
      waiting[u] = 1'b0;
      for (int i = 0; i < n; i++) begin
        e = u * NV + i;
        if (edge_ok[e] && waiting[i] && {1'b0, edge_wt[e]} < key[i]) begin
          key[i] = {1'b0, edge_wt[e]};
          par[i] = u[4:0];
          has_par[i] = 1'b1;
        end
      end
    end
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (has_par[i]) begin
        r = '{parent: par[i], child: i[4:0], wt: key[i][15:0], total: '0,
              tot: 1'b0, lst: 1'b0};
        tree_q.insert(tree_q.size(), r);
        sum += key[i];
      end
    end
    r = '{parent: '0, child: '0, wt: '0, total: sum, tot: 1'b1, lst: 1'b1};
    tree_q.insert(tree_q.size(), r);
  endtask

  task automatic flag(input string fname, input longint exp_v, input longint act_v);
    errors++;
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, fname, exp_v, act_v);
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    runs_seen = 0;
    results_seen = 0;
    count_reg = 6'd32;
    for (int i = 0; i < NV*NV; i++) begin
      edge_ok[i] = 1'b0;
      edge_wt[i] = '0;
    end
  end

  always @(posedge clk) begin
    tree_result_t x;
    if (!rst) begin
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (in_valid && in_ready) begin
        if (action == ACT_WRITE) begin
          edge_ok[from_vertex*NV + to_vertex] = edge_present;
          edge_wt[from_vertex*NV + to_vertex] = edge_present ? weight : '0;
        end else begin
          runs_seen++;
          build_tree(from_vertex);
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (tree_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: parent %0d child %0d total %0d",
                   $time, parent_vertex, child_vertex, total_distance);
        end else begin
          x = tree_q.pop_front();
          if (parent_vertex != x.parent) flag("parent_vertex", x.parent, parent_vertex);
          if (child_vertex != x.child) flag("child_vertex", x.child, child_vertex);
          if (edge_weight != x.wt) flag("edge_weight", x.wt, edge_weight);
          if (total_distance != x.total) flag("total_distance", x.total, total_distance);
          if (is_total != x.tot) flag("is_total", x.tot, is_total);
          if (last != x.lst) flag("last", x.lst, last);
        end
      end
      outstanding = tree_q.size();
    end
  end

endmodule

FILE: verif/prim_mst_adjacency_matrix_tb.sv
// ----------------------------------------------------------------------------
// prim_mst_adjacency_matrix_tb
// Drives matrix writes and tree runs into the Prim tree block under several
// vertex counts, with random gaps and result stalls. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prim_mst_adjacency_matrix_tb;
  import pmst_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [4:0]  from_vertex;
  logic [4:0]  to_vertex;
  logic        edge_present;
  logic [15:0] weight;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  parent_vertex;
  logic [4:0]  child_vertex;
  logic [15:0] edge_weight;
  logic [20:0] total_distance;
  logic        is_total;
  logic        last;

  int errors, outstanding, runs_seen, results_seen;
  int items_sent;
  int cfg_writes;
  bit send_burst, recv_burst;

  prim_mst_adjacency_matrix i_dut (.*);

  pmst_tree_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic send_item(input logic act, input logic [4:0] src, input logic [4:0] dst,
                           input logic present, input logic [15:0] w);
    int gap;
    if (($urandom & 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    from_vertex  <= src;
    to_vertex    <= dst;
    edge_present <= present;
    weight       <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_edge(input logic [4:0] src, input logic [4:0] dst,
                            input logic present, input logic [15:0] w);
    send_item(ACT_WRITE, src, dst, present, w);
  endtask

  task automatic run_tree(input logic [4:0] start);
    send_item(ACT_RUN, start, 5'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic set_count(input logic [5:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int w;
      if (($urandom & 15) == 0) recv_burst = !recv_burst;
      w = recv_burst ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int n, lim, edges, nruns;
    logic [4:0] s, d;
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    action       <= ACT_WRITE;
    from_vertex  <= '0;
    to_vertex    <= '0;
    edge_present <= 1'b0;
    weight       <= '0;
    items_sent   = 0;
    cfg_writes   = 0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_count(6'd32);
    write_edge(5'd0, 5'd31, 1'b1, 16'hFFFF);
    write_edge(5'd31, 5'd0, 1'b1, 16'h0000);
    write_edge(5'd0, 5'd1, 1'b1, 16'd5);
    write_edge(5'd1, 5'd2, 1'b1, 16'd5);
    write_edge(5'd0, 5'd2, 1'b1, 16'd5);
    write_edge(5'd2, 5'd3, 1'b1, 16'd7);
    write_edge(5'd2, 5'd3, 1'b0, 16'd9);
    write_edge(5'd31, 5'd31, 1'b1, 16'd1234);
    write_edge(5'd3, 5'd1, 1'b1, 16'hAAAA);
    write_edge(5'd1, 5'd3, 1'b1, 16'h5555);
    run_tree(5'd0);
    run_tree(5'd31);
    set_count(6'd4);
    write_edge(5'd4, 5'd5, 1'b1, 16'd3);
    run_tree(5'd0);
    run_tree(5'd7);
    set_count(6'd0);
    run_tree(5'd0);
    set_count(6'd63);
    run_tree(5'd3);
    set_count(6'd1);
    run_tree(5'd0);
    run_tree(5'd1);

    while (items_sent < 170) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        2:       n = $urandom_range(32, 63);
        default: n = $urandom_range(2, 8);
      endcase
      set_count(6'(n));
      lim = (n == 0) ? 1 : (n > 32 ? 32 : n);
      edges = $urandom_range(3, 14);
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          s = 5'($urandom_range(0, lim - 1));
          d = 5'($urandom_range(0, lim - 1));
        end else begin
          s = 5'($urandom);
          d = 5'($urandom);
        end
        write_edge(s, d, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 12)) : 16'($urandom));
      end
      nruns = $urandom_range(1, 3);
      for (int i = 0; i < nruns; i++)
        run_tree($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, lim - 1)));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d items (%0d tree runs) over %0d count settings; %0d results checked.",
             items_sent, runs_seen, cfg_writes, results_seen);
    if (errors == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
